[hw/rtl/hkrb_pkg.sv]
// Shared types and constants for the HID keyboard report builder.
// Used by every module in hw/rtl; it depends on nothing else.
`default_nettype none

package hkrb_pkg;

    localparam int SLOT_COUNT   = 6;
    localparam int TABLE_DEPTH  = 256;
    localparam int REPORT_SLOTS = 6;
    localparam int SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);

    // Operation codes.
    localparam logic [1:0] FUNC_PRESS       = 2'd0;
    localparam logic [1:0] FUNC_RELEASE     = 2'd1;
    localparam logic [1:0] FUNC_RELEASE_ALL = 2'd2;
    localparam logic [1:0] FUNC_LOAD        = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT  = 2'd2;

    localparam logic [7:0] GUI_CODE     = 8'd131;
    localparam logic [7:0] GUI_MOD      = 8'h08;
    localparam logic [7:0] MAP_SHIFT    = 8'h80;
    localparam logic [7:0] MAP_ALTGR    = 8'h40;
    localparam logic [7:0] LSHIFT_MOD   = 8'h02;
    localparam logic [7:0] RALT_MOD     = 8'h40;
    localparam logic [7:0] USAGE_MASK   = 8'h3F;
    localparam logic [7:0] ALIAS_USAGE  = 8'h03;
    localparam logic [7:0] ALIAS_TARGET = 8'h64;

    typedef logic [SLOT_COUNT-1:0][7:0] slot_array_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_code;
        logic [7:0] map_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       report_sent;
        logic [7:0] modifier_bits;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } rsp_t;

    // Control from the sequencer to the slot file.
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] scan_idx;
        logic                  wr_en;
        logic [SLOT_IDX_W-1:0] wr_idx;
        logic [7:0]            wr_data;
        logic                  clear_all;
    } slot_ctrl_t;

    // Result of the shared comparator for the slot under scan.
    typedef struct packed {
        logic match;
        logic empty;
    } slot_cmp_t;

endpackage

`default_nettype wire

[hw/rtl/hid_keyboard_report_builder.sv]
// Top level of the HID keyboard report builder: sequencer, modifier byte
// and response register. Depends on hkrb_pkg, hkrb_layout_mem, hkrb_slot_file.
//
// Usage: each request on cmd (valid/ready) is a press, release, release-all
// or layout-table load. Exactly one response leaves on rsp (valid/ready) per
// request, carrying the status, whether a report goes to the host, and the
// whole report (modifier byte and six key slots) after the request.
// Steps: a request is taken in the idle state, then the layout table is read,
// the key slots are scanned in turn through one shared comparator, the change
// is applied and the response register is loaded. A new request is taken only
// in the idle state, so the block is through with one request before it takes
// the next.
// A request can be taken while the previous response still waits; if the
// receiver stalls, the block holds its finished work in the final step until
// the response register frees, and takes no request meanwhile.
// Reset empties the report, clears the modifier byte and marks every layout
// entry unmapped at once through per-entry valid bits; no clearing pass.
`default_nettype none

module hid_keyboard_report_builder
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire hkrb_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output hkrb_pkg::rsp_t      rsp
);
    import hkrb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic                  range_reg;
    logic [7:0]            entry_reg;
    logic [7:0]            usage_reg;
    logic                  gui_reg;
    logic [SLOT_IDX_W-1:0] scan_idx_reg;
    logic                  found_reg;
    logic                  empty_found_reg;
    logic [SLOT_IDX_W-1:0] empty_idx_reg;
    logic [7:0]            mod_reg;
    logic [1:0]            status_reg;
    logic                  sent_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  accept;
    logic                  range_ok;
    logic [7:0]            mem_data;
    logic [7:0]            entry;
    logic [7:0]            usage_raw;
    logic                  mapped;
    logic                  add_ok;
    logic                  rsp_free;
    logic                  scan_last;
    logic                  press_wr;
    logic                  release_wr;
    logic                  table_wr;
    slot_ctrl_t            slot_ctrl;
    slot_cmp_t             slot_cmp;
    slot_array_t           slots;
    logic [7:0]            view [REPORT_SLOTS];

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign range_ok  = ({1'b0, cmd.key_code} < 9'(TABLE_DEPTH));
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign scan_last = (scan_idx_reg == SLOT_IDX_W'(SLOT_COUNT - 1));
    assign mapped    = (entry_reg != 8'h00);
    assign add_ok    = found_reg || empty_found_reg;
    assign table_wr  = (state_reg == S_APPLY) && (cmd_reg.func == FUNC_LOAD) && range_reg;

    hkrb_layout_mem u_layout
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cmd.key_code[ADDR_W-1:0]),
        .wr_en   (table_wr),
        .wr_addr (cmd_reg.key_code[ADDR_W-1:0]),
        .wr_data (cmd_reg.map_value),
        .rd_data (mem_data)
    );

    // Codes beyond the table read as unmapped.
    assign entry     = range_reg ? mem_data : 8'h00;
    assign usage_raw = entry & USAGE_MASK;

    assign release_wr = (state_reg == S_SCAN) && (cmd_reg.func == FUNC_RELEASE) && mapped
                        && (usage_reg != 8'h00) && slot_cmp.match;
    assign press_wr   = (state_reg == S_APPLY) && (cmd_reg.func == FUNC_PRESS)
                        && (gui_reg || mapped) && !found_reg && empty_found_reg;

    always_comb
    begin
        slot_ctrl.scan_idx  = scan_idx_reg;
        slot_ctrl.wr_en     = release_wr || press_wr;
        slot_ctrl.wr_idx    = press_wr ? empty_idx_reg : scan_idx_reg;
        slot_ctrl.wr_data   = press_wr ? usage_reg : 8'h00;
        slot_ctrl.clear_all = (state_reg == S_APPLY) && (cmd_reg.func == FUNC_RELEASE_ALL);
    end

    hkrb_slot_file u_slots
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (slot_ctrl),
        .cmp_usage (usage_reg),
        .cmp       (slot_cmp),
        .slots     (slots)
    );

    for (genvar k = 0; k < REPORT_SLOTS; k++)
    begin : g_view
        if (k < SLOT_COUNT)
        begin : g_used
            assign view[k] = slots[k];
        end
        else
        begin : g_unused
            assign view[k] = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_idx_reg    <= '0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            mod_reg         <= 8'h00;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_READ:
                begin
                    scan_idx_reg    <= '0;
                    found_reg       <= 1'b0;
                    empty_found_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    if (slot_cmp.match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (slot_cmp.empty && !empty_found_reg)
                    begin
                        empty_found_reg <= 1'b1;
                    end
                    if (!scan_last)
                    begin
                        scan_idx_reg <= SLOT_IDX_W'(scan_idx_reg + 1'b1);
                    end
                end
                S_APPLY:
                begin
                    case (cmd_reg.func)
                        FUNC_PRESS:
                        begin
                            if (gui_reg)
                            begin
                                mod_reg <= mod_reg | GUI_MOD;
                            end
                            else if (mapped)
                            begin
                                mod_reg <= mod_reg
                                    | (((entry_reg & MAP_SHIFT) != 8'h00) ? LSHIFT_MOD : 8'h00)
                                    | (((entry_reg & MAP_ALTGR) != 8'h00) ? RALT_MOD : 8'h00);
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (mapped)
                            begin
                                mod_reg <= mod_reg
                                    & ~(((entry_reg & MAP_SHIFT) != 8'h00) ? LSHIFT_MOD : 8'h00)
                                    & ~(((entry_reg & MAP_ALTGR) != 8'h00) ? RALT_MOD : 8'h00);
                            end
                        end
                        FUNC_RELEASE_ALL:
                        begin
                            mod_reg <= 8'h00;
                        end
                        default:
                        begin
                            mod_reg <= mod_reg;
                        end
                    endcase
                end
                default:
                begin
                    scan_idx_reg <= scan_idx_reg;
                end
            endcase

            if (state_reg == S_EMIT && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; these carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            range_reg <= range_ok;
        end
        if (state_reg == S_READ)
        begin
            entry_reg <= entry;
            gui_reg   <= (cmd_reg.func == FUNC_PRESS) && (cmd_reg.key_code == GUI_CODE);
            // The GUI key adds no usage; it only needs a free slot.
            if ((cmd_reg.func == FUNC_PRESS) && (cmd_reg.key_code == GUI_CODE))
            begin
                usage_reg <= 8'h00;
            end
            else
            begin
                usage_reg <= (usage_raw == ALIAS_USAGE) ? ALIAS_TARGET : usage_raw;
            end
        end
        if (state_reg == S_SCAN && slot_cmp.empty && !empty_found_reg)
        begin
            empty_idx_reg <= scan_idx_reg;
        end
        if (state_reg == S_APPLY)
        begin
            case (cmd_reg.func)
                FUNC_PRESS:
                begin
                    if (!gui_reg && !mapped)
                    begin
                        status_reg <= ST_UNMAPPED;
                        sent_reg   <= 1'b0;
                    end
                    else if (add_ok)
                    begin
                        status_reg <= ST_DONE;
                        sent_reg   <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_NO_SLOT;
                        sent_reg   <= 1'b0;
                    end
                end
                FUNC_RELEASE:
                begin
                    if (mapped)
                    begin
                        status_reg <= ST_DONE;
                        sent_reg   <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_UNMAPPED;
                        sent_reg   <= 1'b0;
                    end
                end
                FUNC_RELEASE_ALL:
                begin
                    status_reg <= ST_DONE;
                    sent_reg   <= 1'b1;
                end
                default:
                begin
                    status_reg <= ST_DONE;
                    sent_reg   <= 1'b0;
                end
            endcase
        end
        if (state_reg == S_EMIT && rsp_free)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.report_sent   <= sent_reg;
            rsp_reg.modifier_bits <= mod_reg;
            rsp_reg.slot_zero     <= view[0];
            rsp_reg.slot_one      <= view[1];
            rsp_reg.slot_two      <= view[2];
            rsp_reg.slot_three    <= view[3];
            rsp_reg.slot_four     <= view[4];
            rsp_reg.slot_five     <= view[5];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted request always starts with the table read.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted request did not start the table read");

    // A new response appears only from the final step of a request.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("response raised outside the final step");

    // A failed request never sends a report.
    a_fail_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ST_DONE) |-> !rsp_reg.report_sent)
        else $error("report sent with a failure status");

    // The scan visits every slot before the change is applied.
    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (state_next == S_APPLY) |-> scan_last)
        else $error("slot scan ended early");

endmodule

`default_nettype wire

[hw/rtl/hkrb_layout_mem.sv]
// Layout table: character code to layout entry, with a valid bit per entry.
// Depends on hkrb_pkg.
`default_nettype none

module hkrb_layout_mem
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [hkrb_pkg::ADDR_W-1:0] rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [hkrb_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    output logic [7:0]                     rd_data
);
    import hkrb_pkg::*;

    logic [7:0]             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [7:0]             data_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // An entry that was never loaded reads as unmapped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : 8'h00;

endmodule

`default_nettype wire

[hw/rtl/hkrb_slot_file.sv]
// Report key slots with the single shared comparator used by the slot scan.
// Depends on hkrb_pkg.
`default_nettype none

module hkrb_slot_file
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hkrb_pkg::slot_ctrl_t ctrl,
    input  wire logic [7:0]           cmp_usage,
    output hkrb_pkg::slot_cmp_t       cmp,
    output hkrb_pkg::slot_array_t     slots
);
    import hkrb_pkg::*;

    slot_array_t slots_reg;
    logic [7:0]  cur_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
        end
        else if (ctrl.clear_all)
        begin
            slots_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            slots_reg[ctrl.wr_idx] <= ctrl.wr_data;
        end
    end

    assign cur_slot  = slots_reg[ctrl.scan_idx];
    assign cmp.match = (cur_slot == cmp_usage);
    assign cmp.empty = (cur_slot == 8'h00);
    assign slots     = slots_reg;

endmodule

`default_nettype wire

[dv/tb_hid_keyboard_report_builder.sv]
// Self-checking testbench for hid_keyboard_report_builder: directed and random
// requests on cmd, each response on rsp checked against a built-in predictor.
// Depends on hkrb_pkg and the block's RTL only.

module tb_hid_keyboard_report_builder;

    timeunit 1ns;
    timeprecision 1ps;

    import hkrb_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int QUIET_ITEMS  = 150;
    localparam int POOL_SIZE    = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 4);

    // Predicts the report after each request and holds the responses still owed.
    class report_scoreboard;
        logic [7:0] held_keys [SLOT_COUNT];
        logic [7:0] mod_byte;
        logic [7:0] char_map [TABLE_DEPTH];
        rsp_t       owed_reports [$];
        int         errors;
        int         n_requests;
        int         n_sent;
        int         n_no_slot;
        int         n_unmapped;

        function new();
            foreach (held_keys[i]) held_keys[i] = 8'h00;
            foreach (char_map[i]) char_map[i] = 8'h00;
            mod_byte   = 8'h00;
            errors     = 0;
            n_requests = 0;
            n_sent     = 0;
            n_no_slot  = 0;
            n_unmapped = 0;
        endfunction

        task report_error(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function logic [7:0] usage_of(logic [7:0] entry);
            logic [7:0] u;
            u = entry & USAGE_MASK;
            return (u == ALIAS_USAGE) ? ALIAS_TARGET : u;
        endfunction

        // Returns 0 only when the usage is absent and every slot is taken.
        function bit place_usage(logic [7:0] u);
            foreach (held_keys[i])
                if (held_keys[i] == u) return 1'b1;
            foreach (held_keys[i])
            begin
                if (held_keys[i] == 8'h00)
                begin
                    held_keys[i] = u;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(cmd_t c);
            rsp_t       r;
            logic [7:0] entry;
            logic [7:0] u;
            r = '0;
            entry = (int'(c.key_code) < TABLE_DEPTH) ? char_map[c.key_code] : 8'h00;
            n_requests++;
            case (c.func)
                FUNC_PRESS:
                begin
                    if (c.key_code == GUI_CODE)
                    begin
                        // The GUI key only sets its modifier; usage 0 fits any empty slot.
                        mod_byte = mod_byte | GUI_MOD;
                        if (place_usage(8'h00)) r.report_sent = 1'b1;
                        else r.status = ST_NO_SLOT;
                    end
                    else if (entry == 8'h00)
                        r.status = ST_UNMAPPED;
                    else
                    begin
                        if (entry & MAP_SHIFT) mod_byte = mod_byte | LSHIFT_MOD;
                        if (entry & MAP_ALTGR) mod_byte = mod_byte | RALT_MOD;
                        if (place_usage(usage_of(entry))) r.report_sent = 1'b1;
                        else r.status = ST_NO_SLOT;
                    end
                end
                FUNC_RELEASE:
                begin
                    if (entry == 8'h00)
                        r.status = ST_UNMAPPED;
                    else
                    begin
                        u = usage_of(entry);
                        if (entry & MAP_SHIFT) mod_byte = mod_byte & ~LSHIFT_MOD;
                        if (entry & MAP_ALTGR) mod_byte = mod_byte & ~RALT_MOD;
                        foreach (held_keys[i])
                            if (u != 8'h00 && held_keys[i] == u) held_keys[i] = 8'h00;
                        r.report_sent = 1'b1;
                    end
                end
                FUNC_RELEASE_ALL:
                begin
                    foreach (held_keys[i]) held_keys[i] = 8'h00;
                    mod_byte = 8'h00;
                    r.report_sent = 1'b1;
                end
                default:
                begin
                    if (int'(c.key_code) < TABLE_DEPTH) char_map[c.key_code] = c.map_value;
                end
            endcase
            if (r.report_sent) n_sent++;
            if (r.status == ST_NO_SLOT) n_no_slot++;
            if (r.status == ST_UNMAPPED) n_unmapped++;
            r.modifier_bits = mod_byte;
            r.slot_zero  = held_keys[0];
            r.slot_one   = (SLOT_COUNT > 1) ? held_keys[1] : 8'h00;
            r.slot_two   = (SLOT_COUNT > 2) ? held_keys[2] : 8'h00;
            r.slot_three = (SLOT_COUNT > 3) ? held_keys[3] : 8'h00;
            r.slot_four  = (SLOT_COUNT > 4) ? held_keys[4] : 8'h00;
            r.slot_five  = (SLOT_COUNT > 5) ? held_keys[5] : 8'h00;
            owed_reports.push_back(r);
        endfunction

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_error($sformatf("%s got %02h, expected %02h", name, got, want));
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (owed_reports.size() == 0)
            begin
                report_error("response arrived with no request outstanding");
                return;
            end
            want = owed_reports.pop_front();
            check_field("status",        got.status,        want.status);
            check_field("report_sent",   got.report_sent,   want.report_sent);
            check_field("modifier_bits", got.modifier_bits, want.modifier_bits);
            check_field("slot_zero",     got.slot_zero,     want.slot_zero);
            check_field("slot_one",      got.slot_one,      want.slot_one);
            check_field("slot_two",      got.slot_two,      want.slot_two);
            check_field("slot_three",    got.slot_three,    want.slot_three);
            check_field("slot_four",     got.slot_four,     want.slot_four);
            check_field("slot_five",     got.slot_five,     want.slot_five);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    report_scoreboard board = new();
    bit quiet = 1'b0;
    int ready_hold = 0;

    hid_keyboard_report_builder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t make_cmd(logic [1:0] f, logic [7:0] k, logic [7:0] m);
        cmd_t c;
        c.func      = f;
        c.key_code  = k;
        c.map_value = m;
        return c;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_cmd(cmd_t c);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        board.note_request(c);
    endtask

    // Response side: check what is taken, then stall in short random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready) board.check_response(rsp);
            if (ready_hold > 0)
            begin
                ready_hold--;
                rsp_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                ready_hold = $urandom_range(1, 3) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin
        int still;
        still = 0;
        while (still < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) still = 0;
            else still++;
        end
        $display("tb: no progress for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, board.owed_reports.size());
        $display("tb_hid_keyboard_report_builder: done, errors");
        $finish;
    end

    initial
    begin
        logic [7:0] pool [POOL_SIZE];
        int         roll;
        logic [7:0] k;
        logic [7:0] m;
        cmd_t       c;

        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: everything but the GUI key reads as unmapped.
        send_cmd(make_cmd(FUNC_PRESS,   8'h61,    8'h00));
        send_cmd(make_cmd(FUNC_RELEASE, 8'h61,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   GUI_CODE, 8'h00));
        send_cmd(make_cmd(FUNC_RELEASE, GUI_CODE, 8'h00));
        send_cmd(make_cmd(FUNC_LOAD,    8'h61,    8'h04));
        send_cmd(make_cmd(FUNC_LOAD,    8'h41,    8'h84));
        send_cmd(make_cmd(FUNC_LOAD,    8'h40,    8'h67));
        send_cmd(make_cmd(FUNC_LOAD,    8'h3C,    8'h03));
        send_cmd(make_cmd(FUNC_LOAD,    8'h00,    8'hFF));
        send_cmd(make_cmd(FUNC_LOAD,    8'hFF,    8'hC0));
        send_cmd(make_cmd(FUNC_PRESS,   8'h61,    8'h00));
        // Same usage again, now with shift: only the modifier changes.
        send_cmd(make_cmd(FUNC_PRESS,   8'h41,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'h40,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'h3C,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'hFF,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'h00,    8'h00));
        send_cmd(make_cmd(FUNC_LOAD,    8'h20,    8'h2C));
        send_cmd(make_cmd(FUNC_LOAD,    8'h32,    8'h1F));
        send_cmd(make_cmd(FUNC_PRESS,   8'h20,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'h32,    8'h00));
        // The report is full now.
        send_cmd(make_cmd(FUNC_PRESS,   GUI_CODE, 8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   8'h41,    8'h00));
        send_cmd(make_cmd(FUNC_RELEASE, 8'h61,    8'h00));
        send_cmd(make_cmd(FUNC_PRESS,   GUI_CODE, 8'h00));
        send_cmd(make_cmd(FUNC_RELEASE, 8'hFF,    8'h00));
        send_cmd(make_cmd(FUNC_RELEASE_ALL, 8'hA5, 8'h5A));

        // Most random requests use a small set of characters so that the
        // report fills up and keys are pressed and released repeatedly.
        foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
        pool[0] = GUI_CODE;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            roll = $urandom_range(0, 99);
            k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 60)
                m = 8'(($urandom_range(0, 3) << 6) | $urandom_range(1, 63));
            else
                m = 8'($urandom_range(0, 255));
            if (roll < 14)
                c = make_cmd(FUNC_LOAD, k, m);
            else if (roll < 60)
                c = make_cmd(FUNC_PRESS, k, m);
            else if (roll < 97)
                c = make_cmd(FUNC_RELEASE, k, m);
            else
                c = make_cmd(FUNC_RELEASE_ALL, k, m);
            send_cmd(c);
        end
        cmd_valid <= 1'b0;

        while (board.owed_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests, %0d reports sent, %0d refused for a full report",
                 board.n_requests, board.n_sent, board.n_no_slot);
        $display("tb: %0d unmapped characters, %0d mismatches",
                 board.n_unmapped, board.errors);
        if (board.errors == 0)
            $display("tb_hid_keyboard_report_builder: done, clean");
        else
            $display("tb_hid_keyboard_report_builder: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hkrb_pkg.sv
hw/rtl/hkrb_layout_mem.sv
hw/rtl/hkrb_slot_file.sv
hw/rtl/hid_keyboard_report_builder.sv
dv/tb_hid_keyboard_report_builder.sv
